### rtl/vc_pkg.sv
package vc_pkg;

  // Request opcodes after classification.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } vc_op_t;

  // Raw request codes on the input channel.
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_STOP  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Sub-channel pattern that matches any owner sub-channel on start.
  localparam logic [3:0] SUB_ANY  = 4'hF;
  localparam logic [3:0] SUB_NONE = 4'h0;

  // Starting value of the least-life search: 0x7fffffff in biased order.
  localparam logic [31:0] LIFE_LIMIT = 32'hFFFF_FFFF;
  localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;

  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);

  typedef struct packed {
    vc_op_t      op;
    logic [15:0] entity;
    logic [3:0]  sub;
    logic [23:0] len;
    logic [30:0] now;
    logic        aud;
  } vc_cmd_t;

  typedef struct packed {
    logic [15:0] owner;
    logic [3:0]  sub;
    logic [31:0] end_time;
    logic        active;
  } vc_voice_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_WRITE = 2'd2,
    ST_DONE  = 2'd3
  } vc_state_t;

endpackage

### rtl/vc_if.sv
interface vc_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [15:0]       entity;
  logic signed [3:0] entity_channel;
  logic [23:0]       sound_length;
  logic [30:0]       now_time;
  logic              audible;

  modport source (output valid, req_type, entity, entity_channel, sound_length, now_time,
                  audible, input ready);
  modport sink (input valid, req_type, entity, entity_channel, sound_length, now_time,
                audible, output ready);
endinterface

interface vc_rsp_if;
  logic       valid;
  logic       ready;
  logic       granted;
  logic [5:0] channel_index;
  logic       evicted_active;

  modport source (output valid, granted, channel_index, evicted_active, input ready);
  modport sink (input valid, granted, channel_index, evicted_active, output ready);
endinterface

### rtl/vc_front.sv
module vc_front (
  input  logic           clk,
  input  logic           rst,
  vc_req_if.sink         req,
  output logic           q_valid,
  output vc_pkg::vc_cmd_t q_data,
  input  logic           q_pop
);

  vc_pkg::vc_cmd_t                 slots [vc_pkg::QDEPTH];
  logic [vc_pkg::QPW-1:0]          wr_ptr;
  logic [vc_pkg::QPW-1:0]          rd_ptr;
  logic [vc_pkg::QPW:0]            count;
  vc_pkg::vc_cmd_t                 cmd_in;
  logic                            push;
  logic                            pop;

  // Decode the raw request code; the unused code becomes a no-op.
  always_comb begin
    cmd_in.entity = req.entity;
    cmd_in.sub    = req.entity_channel;
    cmd_in.len    = req.sound_length;
    cmd_in.now    = req.now_time;
    cmd_in.aud    = req.audible;
    case (req.req_type)
      vc_pkg::REQ_START: cmd_in.op = vc_pkg::OP_START;
      vc_pkg::REQ_STOP:  cmd_in.op = vc_pkg::OP_STOP;
      vc_pkg::REQ_CLEAR: cmd_in.op = vc_pkg::OP_CLEAR;
      default:           cmd_in.op = vc_pkg::OP_NONE;
    endcase
  end

  assign req.ready = (count != (vc_pkg::QPW+1)'(vc_pkg::QDEPTH));
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != '0);
  assign pop       = q_pop && q_valid;
  assign q_data    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/vc_back.sv
module vc_back #(
  parameter int NUM_VOICES = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [15:0]     viewer,
  input  logic            q_valid,
  input  vc_pkg::vc_cmd_t q_data,
  output logic            q_pop,
  vc_rsp_if.source        rsp
);

  localparam int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CW = $clog2(NUM_VOICES + 1);

  vc_pkg::vc_voice_t   mem [NUM_VOICES];
  logic [NUM_VOICES-1:0] valid;

  vc_pkg::vc_state_t state;
  vc_pkg::vc_state_t state_next;
  vc_pkg::vc_cmd_t   cmd;
  logic [CW-1:0]     cnt;

  logic              rd_vld;
  logic [IW-1:0]     rd_idx;
  vc_pkg::vc_voice_t rd_ent;
  logic              rd_ok;

  logic [31:0]       best;
  logic [IW-1:0]     pick;
  logic              have;
  logic              pick_act;

  logic              out_valid;
  logic              out_granted;
  logic [5:0]        out_index;
  logic              out_evicted;

  vc_pkg::vc_voice_t e;
  vc_pkg::vc_voice_t wr_ent;
  logic              use_rd;
  logic              start_hit;
  logic              stop_hit;
  logic              protect;
  logic [31:0]       life;
  logic              better;
  logic              hit;
  logic              last;
  logic              issue;
  logic              mem_we;
  logic              clear_all;
  logic              out_load;

  // Entry evaluation on the registered read data.
  always_comb begin
    e         = rd_ok ? rd_ent : '0;
    use_rd    = rd_vld && (state == vc_pkg::ST_SCAN);
    start_hit = (cmd.sub != vc_pkg::SUB_NONE) && (e.owner == cmd.entity) &&
                ((e.sub == cmd.sub) || (cmd.sub == vc_pkg::SUB_ANY));
    stop_hit  = (e.owner == cmd.entity) && (e.sub == cmd.sub);
    protect   = (e.owner == viewer) && (cmd.entity != viewer) && e.active;
    life      = (e.end_time - {1'b0, cmd.now}) ^ vc_pkg::SIGN_BIT;
    better    = (cmd.op == vc_pkg::OP_START) && !protect && (life < best);
    hit       = use_rd && ((cmd.op == vc_pkg::OP_START) ? start_hit : stop_hit);
    last      = use_rd && (rd_idx == IW'(NUM_VOICES - 1));
  end

  always_comb begin
    wr_ent.owner = cmd.entity;
    wr_ent.sub   = cmd.sub;
    if ((cmd.op == vc_pkg::OP_START) && cmd.aud) begin
      wr_ent.end_time = {1'b0, cmd.now} + {8'b0, cmd.len};
      wr_ent.active   = 1'b1;
    end else begin
      wr_ent.end_time = '0;
      wr_ent.active   = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      vc_pkg::ST_IDLE: begin
        if (q_valid) begin
          if ((q_data.op == vc_pkg::OP_START) || (q_data.op == vc_pkg::OP_STOP)) begin
            state_next = vc_pkg::ST_SCAN;
          end else begin
            state_next = vc_pkg::ST_DONE;
          end
        end
      end
      vc_pkg::ST_SCAN: begin
        if (hit) begin
          state_next = vc_pkg::ST_WRITE;
        end else if (last) begin
          state_next = (have || better) ? vc_pkg::ST_WRITE : vc_pkg::ST_DONE;
        end
      end
      vc_pkg::ST_WRITE: state_next = vc_pkg::ST_DONE;
      vc_pkg::ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          state_next = vc_pkg::ST_IDLE;
        end
      end
      default: state_next = vc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == vc_pkg::ST_IDLE) && q_valid;
    clear_all = q_pop && (q_data.op == vc_pkg::OP_CLEAR);
    issue     = (state == vc_pkg::ST_SCAN) && (cnt != CW'(NUM_VOICES));
    mem_we    = (state == vc_pkg::ST_WRITE);
    out_load  = (state == vc_pkg::ST_DONE) && (!out_valid || rsp.ready);
  end

  // Voice table: one read port for the scan, one write port for the update.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pick] <= wr_ent;
    end
    if (issue) begin
      rd_ent <= mem[cnt[IW-1:0]];
      rd_ok  <= valid[cnt[IW-1:0]];
      rd_idx <= cnt[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= vc_pkg::ST_IDLE;
      valid  <= '0;
      rd_vld <= 1'b0;
      cnt    <= '0;
      have   <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (clear_all) begin
        valid <= '0;
      end else if (mem_we) begin
        valid[pick] <= 1'b1;
      end
      if (q_pop) begin
        cnt  <= '0;
        have <= 1'b0;
      end else begin
        if (issue) begin
          cnt <= cnt + 1'b1;
        end
        if (use_rd && (hit || better)) begin
          have <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd      <= q_data;
      best     <= vc_pkg::LIFE_LIMIT;
      pick     <= '0;
      pick_act <= 1'b0;
    end else if (use_rd && (hit || better)) begin
      pick     <= rd_idx;
      pick_act <= e.active;
      if (!hit) begin
        best <= life;
      end
    end
  end

  // Result register; the front keeps accepting while a result waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_granted <= have;
      out_index   <= have ? 6'(pick) : 6'd0;
      out_evicted <= have && pick_act;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.granted        = out_granted;
  assign rsp.channel_index  = out_index;
  assign rsp.evicted_active = out_evicted;

endmodule

### rtl/voice_channel_allocator.sv
// Channel  Dir  Handshake      Payload
// req      in   valid/ready    req_type, entity, entity_channel, sound_length, now_time, audible
// rsp      out  valid/ready    granted, channel_index, evicted_active
// cfg      in   cfg_wr_en      cfg_wr_data (viewer entity)
//
// Start and stop run through dequeue, a scan with one registered table read
// per voice, write and result when a voice is written, and skip the write
// when nothing is written; a match ends the scan early. Clear and unused
// codes go from dequeue straight to the result.
// The rate is set by the single read port of the voice table.
// rst is synchronous: viewer goes to 0, all voices become empty (valid bits
// cleared), the request queue and result register empty out.
// A two-item queue parts the request side from the scan engine, and the
// result register lets the engine finish while rsp is stalled.
module voice_channel_allocator #(
  parameter int NUM_VOICES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  vc_req_if.sink      req,
  vc_rsp_if.source    rsp
);

  logic [15:0]     viewer;
  logic            q_valid;
  logic            q_pop;
  vc_pkg::vc_cmd_t q_data;

  // Listener entity; its active voices are protected from other entities.
  always_ff @(posedge clk) begin
    if (rst) begin
      viewer <= '0;
    end else if (cfg_wr_en) begin
      viewer <= cfg_wr_data;
    end
  end

  // Front: accept, decode and queue requests.
  vc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  // Back: scan the voice table, pick or stop a voice, post the result.
  vc_back #(
    .NUM_VOICES (NUM_VOICES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .viewer  (viewer),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule

### sim/voice_table_board_pkg.sv
package voice_table_board_pkg;

  import vc_pkg::*;

  localparam int VOICES = 8;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [15:0]       entity;
    logic signed [3:0] entity_channel;
    logic [23:0]       sound_length;
    logic [30:0]       now_time;
    logic              audible;
  } request_t;

  typedef struct packed {
    logic       granted;
    logic [5:0] channel_index;
    logic       evicted_active;
  } grant_t;

  // Mirror of the voice table plus the grants still owed by the block.
  class voice_table_board;
    logic [15:0] viewer;
    logic [15:0] owner[VOICES];
    logic [3:0]  owner_sub[VOICES];
    logic [31:0] end_at[VOICES];
    logic        live[VOICES];
    grant_t      awaited[$];

    int mismatches;
    int starts, stops, clears, spares;
    int grants, cuts, refused;

    function new();
      viewer     = '0;
      mismatches = 0;
      starts     = 0;
      stops      = 0;
      clears     = 0;
      spares     = 0;
      grants     = 0;
      cuts       = 0;
      refused    = 0;
      wipe();
    endfunction

    function void wipe();
      for (int i = 0; i < VOICES; i++) begin
        owner[i]     = '0;
        owner_sub[i] = '0;
        end_at[i]    = '0;
        live[i]      = 1'b0;
      end
    endfunction

    function void set_viewer(logic [15:0] v);
      viewer = v;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Work out the grant for one accepted request and update the table.
    function void note_request(request_t r);
      grant_t      res;
      logic [3:0]  sub;
      logic [31:0] best;
      logic [31:0] life;
      int          pick;
      bit          hit;
      res  = '0;
      sub  = r.entity_channel;
      pick = -1;
      hit  = 1'b0;
      case (r.req_type)
        REQ_START: begin
          starts++;
          best = LIFE_LIMIT;
          for (int i = 0; i < VOICES && !hit; i++) begin
            if (sub != SUB_NONE && owner[i] == r.entity &&
                (owner_sub[i] == sub || sub == SUB_ANY)) begin
              pick = i;
              hit  = 1'b1;
            end else if (!(live[i] && owner[i] == viewer && r.entity != viewer)) begin
              // signed remaining life, compared in offset-binary order
              life = (end_at[i] - {1'b0, r.now_time}) ^ SIGN_BIT;
              if (life < best) begin
                best = life;
                pick = i;
              end
            end
          end
          if (pick >= 0) begin
            res.granted        = 1'b1;
            res.channel_index  = 6'(pick);
            res.evicted_active = live[pick];
            owner[pick]        = r.entity;
            owner_sub[pick]    = sub;
            live[pick]         = r.audible;
            end_at[pick]       = r.audible ? {1'b0, r.now_time} + {8'd0, r.sound_length}
                                           : 32'd0;
          end else begin
            refused++;
          end
        end
        REQ_STOP: begin
          stops++;
          for (int i = 0; i < VOICES && !hit; i++) begin
            if (owner[i] == r.entity && owner_sub[i] == sub) begin
              hit                = 1'b1;
              res.granted        = 1'b1;
              res.channel_index  = 6'(i);
              res.evicted_active = live[i];
              end_at[i]          = '0;
              live[i]            = 1'b0;
            end
          end
        end
        REQ_CLEAR: begin
          clears++;
          wipe();
        end
        default: spares++;
      endcase
      if (res.granted) grants++;
      if (res.evicted_active) cuts++;
      awaited.push_back(res);
    endfunction

    function void check_result(logic granted, logic [5:0] channel_index,
                               logic evicted_active);
      grant_t want;
      if (awaited.size() == 0) begin
        $error("unrequested result: granted %0d channel_index %0d evicted_active %0d",
               granted, channel_index, evicted_active);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (granted !== want.granted) begin
        $error("granted: expected %0d, got %0d", want.granted, granted);
        mismatches++;
      end
      if (channel_index !== want.channel_index) begin
        $error("channel_index: expected %0d, got %0d", want.channel_index, channel_index);
        mismatches++;
      end
      if (evicted_active !== want.evicted_active) begin
        $error("evicted_active: expected %0d, got %0d", want.evicted_active, evicted_active);
        mismatches++;
      end
    endfunction
  endclass

endpackage

### sim/voice_channel_allocator_tb.sv
module voice_channel_allocator_tb;

  import vc_pkg::*;
  import voice_table_board_pkg::*;

  // Request code the block must ignore.
  localparam logic [1:0] REQ_SPARE = 2'd3;

  // Twice a full scan, waited out before touching the viewer.
  localparam int SETTLE_CYCLES = 2 * (VOICES + 4);
  // Worst case per item is gap + scan + stall; this limit is far above the total.
  localparam int CYCLE_LIMIT   = 400_000;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 225;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  vc_req_if req_ch ();
  vc_rsp_if rsp_ch ();

  voice_table_board board = new();

  int          cycle_count;
  bit          steady;        // no gaps on either side in this phase
  logic [15:0] phase_viewer;
  logic [30:0] game_now;      // running game clock for random requests
  logic [19:0] recent_pairs[$]; // {entity, sub-channel} of recent starts

  voice_channel_allocator #(
    .NUM_VOICES (VOICES)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Monitor: both handshakes sampled at the rising edge. A request is noted
  // before any result of the same edge is checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        board.note_request({req_ch.req_type, req_ch.entity, req_ch.entity_channel,
                            req_ch.sound_length, req_ch.now_time, req_ch.audible});
      if (rsp_ch.valid && rsp_ch.ready)
        board.check_result(rsp_ch.granted, rsp_ch.channel_index, rsp_ch.evicted_active);
    end
  end

  // Result side back-pressure: a fresh random stall for every item, none in a steady phase.
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      @(negedge clk);
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("voice_channel_allocator_tb: errors");
    $finish;
  end

  function automatic request_t pack_req(logic [1:0] kind, logic [15:0] ent,
                                        logic signed [3:0] sub, logic [23:0] len,
                                        logic [30:0] now, logic aud);
    request_t r;
    r.req_type       = kind;
    r.entity         = ent;
    r.entity_channel = sub;
    r.sound_length   = len;
    r.now_time       = now;
    r.audible        = aud;
    return r;
  endfunction

  // Entities mostly come from a small pool so that owners collide; the viewer
  // shows up often to exercise protection.
  function automatic logic [15:0] pool_entity();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return phase_viewer;
    if (roll < 85) return 16'($urandom_range(0, 5));
    return 16'($urandom);
  endfunction

  function automatic logic [3:0] pool_sub();
    int s;
    s = $urandom_range(0, 9);
    return (s == 0) ? SUB_ANY : 4'(s % 8);
  endfunction

  // Mostly start/stop pairs on the running clock, with some clears, stray
  // stops, jumps in time and ignored codes mixed in.
  function automatic request_t random_request();
    request_t    r;
    logic [19:0] pair;
    int          roll;
    int          lroll;
    roll     = $urandom_range(0, 99);
    lroll    = $urandom_range(0, 99);
    game_now = game_now + 31'($urandom_range(0, 3000));
    r = pack_req(REQ_START, pool_entity(), pool_sub(), 24'($urandom_range(0, 20000)),
                 game_now, $urandom_range(0, 99) < 80);
    if (lroll >= 95)      r.sound_length = 24'($urandom);
    else if (lroll >= 70) r.sound_length = 24'($urandom_range(0, 16'hFFFF));
    if ($urandom_range(0, 99) < 3) r.now_time = 31'($urandom);
    if (roll < 58) begin
      recent_pairs.push_back({r.entity, 4'(r.entity_channel)});
      if (recent_pairs.size() > 16) void'(recent_pairs.pop_front());
    end else if (roll < 92) begin
      r.req_type = REQ_STOP;
      if (recent_pairs.size() != 0 && $urandom_range(0, 99) < 70) begin
        pair             = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
        r.entity         = pair[19:4];
        r.entity_channel = pair[3:0];
      end
    end else if (roll < 97) begin
      r.req_type = REQ_CLEAR;
    end else begin
      r.req_type = REQ_SPARE;
    end
    return r;
  endfunction

  // Present one item after an optional gap; returns on the falling edge after
  // the accepting edge, with valid still high for a back-to-back item.
  task automatic send_request(request_t r);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.req_type       <= r.req_type;
    req_ch.entity         <= r.entity;
    req_ch.entity_channel <= r.entity_channel;
    req_ch.sound_length   <= r.sound_length;
    req_ch.now_time       <= r.now_time;
    req_ch.audible        <= r.audible;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Stop sending, wait for every owed result, then let the engine go quiet.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_viewer(logic [15:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    board.set_viewer(v);
    phase_viewer = v;
  endtask

  initial begin
    rst                   = 1'b1;
    cfg_wr_en             = 1'b0;
    cfg_wr_data           = '0;
    req_ch.valid          = 1'b0;
    req_ch.req_type       = REQ_START;
    req_ch.entity         = '0;
    req_ch.entity_channel = '0;
    req_ch.sound_length   = '0;
    req_ch.now_time       = '0;
    req_ch.audible        = 1'b0;
    steady                = 1'b0;
    phase_viewer          = '0;
    game_now              = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed: viewer at the top entity ----
    write_viewer(16'hFFFF);
    // stop on a fresh table: entity 0 / sub 0 matches the empty channel 0
    send_request(pack_req(REQ_STOP, 16'h0000, 4'sd0, 24'h0, 31'h0, 1'b0));
    // viewer fills all but one channel with the longest sounds at the latest time
    for (int s = 1; s <= 7; s++)
      send_request(pack_req(REQ_START, 16'hFFFF, 4'(s), 24'hFF_FFFF, 31'h7FFF_FFFF, 1'b1));
    // sub-channel 0 never reuses an owned channel, takes the last empty one
    send_request(pack_req(REQ_START, 16'hFFFF, 4'sd0, 24'hFF_FFFF, 31'h7FFF_FFFF, 1'b1));
    // all channels protected for another entity: refused
    send_request(pack_req(REQ_START, 16'h0001, 4'sd3, 24'd10, 31'h0, 1'b1));
    // wildcard sub-channel reclaims the first channel the viewer owns
    send_request(pack_req(REQ_START, 16'hFFFF, SUB_ANY, 24'd100, 31'h0, 1'b1));
    // inaudible claim: channel taken but left inactive
    send_request(pack_req(REQ_START, 16'hFFFF, 4'sd0, 24'd500, 31'h0, 1'b0));
    // stop twice: second hit finds the silenced channel still owned
    send_request(pack_req(REQ_STOP, 16'hFFFF, 4'sd5, 24'h0, 31'h0, 1'b0));
    send_request(pack_req(REQ_STOP, 16'hFFFF, 4'sd5, 24'h0, 31'h0, 1'b0));
    send_request(pack_req(REQ_STOP, 16'h0002, 4'sd7, 24'h0, 31'h0, 1'b0));
    send_request(pack_req(REQ_SPARE, 16'h1234, 4'sd2, 24'h0, 31'h0, 1'b1));
    send_request(pack_req(REQ_CLEAR, 16'h0000, 4'sd0, 24'h0, 31'h0, 1'b0));
    // every channel ends exactly 0x7fffffff after time 0: no life is short enough
    for (int e = 0; e < VOICES; e++)
      send_request(pack_req(REQ_START, 16'h0100 + 16'(e), 4'sd1, 24'h0, 31'h7FFF_FFFF,
                            1'b1));
    send_request(pack_req(REQ_START, 16'h0200, 4'sd1, 24'h0, 31'h0, 1'b1));

    // ---- random phases, each after its own viewer write ----
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_viewer(16'h0000);
        1: write_viewer(16'h0003);
        2: write_viewer(16'hFFFF);
        3: write_viewer(16'($urandom));
        4: write_viewer(16'h0001);
        default: write_viewer(16'h0000);
      endcase
      steady = (p == 2);
      repeat (PHASE_ITEMS) send_request(random_request());
    end
    steady = 1'b0;
    settle();

    $display("covered %0d starts (%0d refused), %0d stops, %0d clears, %0d ignored codes",
             board.starts, board.refused, board.stops, board.clears, board.spares);
    $display("%0d grants, %0d cut an active sound, %0d cycles, 7 viewer writes",
             board.grants, board.cuts, cycle_count);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("voice_channel_allocator_tb: clean");
    else
      $display("voice_channel_allocator_tb: errors");
    $finish;
  end

endmodule

### sim.f
rtl/vc_pkg.sv
rtl/vc_if.sv
rtl/vc_front.sv
rtl/vc_back.sv
rtl/voice_channel_allocator.sv
sim/voice_table_board_pkg.sv
sim/voice_channel_allocator_tb.sv
